>>> rtl/text_console_cursor_scroll_core_macros.svh
// Assertion macros shared by the console core modules.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_CORE_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define TCC_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("console core check failed");

// Check that cond holds in the cycle after trig.
`define TCC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("console core check failed");

`endif

>>> rtl/tcc_pkg.sv
// Shared types, constants and helper functions of the console core.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COLS   = 40;
    localparam int ROWS   = 24;
    localparam int CELLS  = COLS * ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 14;

    localparam logic [7:0]        BLANK      = 8'h20;
    localparam logic [ADDR_W-1:0] BASE_RESET = 14'd2048;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] REQ_PUT    = 3'd0;
    localparam logic [2:0] REQ_NL     = 3'd1;
    localparam logic [2:0] REQ_MOVE   = 3'd2;
    localparam logic [2:0] REQ_SET    = 3'd3;
    localparam logic [2:0] REQ_PUT_AT = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [1:0] OP_NONE         = 2'd0;
    localparam logic [1:0] OP_WRITE        = 2'd1;
    localparam logic [1:0] OP_SCROLL       = 2'd2;
    localparam logic [1:0] OP_WRITE_SCROLL = 2'd3;

    typedef struct packed {
        logic [2:0] req_type;
        logic       advance;
        logic [7:0] char_code;
        logic [1:0] direction;
        logic [7:0] col;
        logic [7:0] row;
    } in_item_t;

    typedef struct packed {
        logic              vram_write;
        logic [ADDR_W-1:0] vram_addr;
        logic [7:0]        vram_data;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
        logic              bad_location;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [CELL_W-1:0] cell_idx;
        logic [7:0]        data;
        out_item_t         res;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
    } cursor_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic cursor_t place_cursor(input logic [7:0] c, input logic [7:0] r);
        logic [7:0] cc;
        logic [7:0] rr;
        cursor_t    res;
        cc = c;
        rr = r;
        if (c == 8'd255)
        begin
            cc = 8'(COLS - 1);
            rr = r - 8'd1;
        end
        else if (c > 8'(COLS - 1))
        begin
            cc = 8'd0;
            rr = r + 8'd1;
        end
        if (rr == 8'd255)
        begin
            rr = 8'(ROWS - 1);
        end
        else if (rr > 8'(ROWS - 1))
        begin
            rr = 8'd0;
        end
        res.x = cc[COL_W-1:0];
        res.y = rr[ROW_W-1:0];
        return res;
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [COL_W-1:0] c,
                                                     input logic [ROW_W-1:0] r);
        logic [CELL_W-1:0] p;
        p = CELL_W'(r) * CELL_W'(COLS);
        return p + CELL_W'(c);
    endfunction

endpackage

>>> rtl/tcc_cmd_fifo.sv
// Short command queue between the classify front and the store back end.
`timescale 1ns / 1ps

module tcc_cmd_fifo
    import tcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    cmd_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> rtl/tcc_front.sv
// Request front end: cursor tracking, request decode and command build.
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_core_macros.svh"

module tcc_front
    import tcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  in_item_t          request,
    output logic              full,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              q_full,
    input  back_status_t      back_status,
    output logic              cmd_push,
    output cmd_t              cmd
);

    logic [COL_W-1:0]  x_reg;
    logic [ROW_W-1:0]  y_reg;
    logic [ADDR_W-1:0] base_reg;
    cursor_t           cur_next;
    logic              accept;

    assign full      = q_full || back_status.clearing;
    assign accept    = push && !full;
    assign cmd_push  = accept;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmd      = '0;
        cur_next = '{x: x_reg, y: y_reg};
        unique case (request.req_type)
            REQ_PUT:
            begin
                cmd.op       = OP_WRITE;
                cmd.cell_idx = cell_index(x_reg, y_reg);
                cmd.data     = request.char_code;
                if (x_reg == COL_W'(COLS - 1) && y_reg == ROW_W'(ROWS - 1))
                begin
                    cmd.op     = OP_WRITE_SCROLL;
                    cur_next.x = '0;
                end
                else if (request.advance)
                begin
                    cur_next = place_cursor(8'(x_reg) + 8'd1, 8'(y_reg));
                end
            end
            REQ_NL:
            begin
                if (y_reg == ROW_W'(ROWS - 1))
                begin
                    cmd.op     = OP_SCROLL;
                    cur_next.x = '0;
                end
                else
                begin
                    cur_next = place_cursor(8'd0, 8'(y_reg) + 8'd1);
                end
            end
            REQ_MOVE:
            begin
                unique case (request.direction)
                    DIR_UP:    cur_next = place_cursor(8'(x_reg), 8'(y_reg) - 8'd1);
                    DIR_DOWN:  cur_next = place_cursor(8'(x_reg), 8'(y_reg) + 8'd1);
                    DIR_LEFT:  cur_next = place_cursor(8'(x_reg) - 8'd1, 8'(y_reg));
                    DIR_RIGHT: cur_next = place_cursor(8'(x_reg) + 8'd1, 8'(y_reg));
                    default:   cur_next = '{x: x_reg, y: y_reg};
                endcase
            end
            REQ_SET:
            begin
                cur_next = place_cursor(request.col, request.row);
            end
            REQ_PUT_AT:
            begin
                if (request.col < 8'(COLS) && request.row < 8'(ROWS))
                begin
                    cmd.op       = OP_WRITE;
                    cmd.cell_idx = cell_index(request.col[COL_W-1:0], request.row[ROW_W-1:0]);
                    cmd.data     = request.char_code;
                end
                else
                begin
                    cmd.res.bad_location = 1'b1;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
        if (cmd.op == OP_WRITE || cmd.op == OP_WRITE_SCROLL)
        begin
            cmd.res.vram_write = 1'b1;
            cmd.res.vram_addr  = base_reg + ADDR_W'(cmd.cell_idx);
            cmd.res.vram_data  = cmd.data;
        end
        cmd.res.scrolled   = (cmd.op == OP_SCROLL || cmd.op == OP_WRITE_SCROLL);
        cmd.res.cursor_col = cur_next.x;
        cmd.res.cursor_row = cur_next.y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            base_reg <= BASE_RESET;
        end
        else
        begin
            if (accept)
            begin
                x_reg <= cur_next.x;
                y_reg <= cur_next.y;
            end
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end
        end
    end

    `TCC_ASSERT_SAME(a_cursor_in_range, 1'b1,
        (x_reg < COL_W'(COLS)) && (y_reg < ROW_W'(ROWS)))
    `TCC_ASSERT_SAME(a_no_accept_while_clearing, back_status.clearing, !accept)

endmodule

>>> rtl/tcc_back.sv
// Store back end: text memory, row scroll walk, reset clear and result register.
`timescale 1ns / 1ps
`include "text_console_cursor_scroll_core_macros.svh"

module tcc_back
    import tcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  cmd_t         q_cmd,
    output logic         q_pop,
    output back_status_t status,
    output logic         empty,
    input  logic         pop,
    output out_item_t    result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_WR    = 3'd2;
    localparam logic [2:0] ST_BLANK = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [7:0]        mem [CELLS];
    logic [7:0]        rdata_reg;
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CELL_W-1:0] ptr_reg;
    logic [CELL_W-1:0] ptr_next;
    logic              scroll_reg;
    logic              scroll_next;
    out_item_t         hold_reg;
    out_item_t         hold_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic              out_free;
    logic              load;
    logic              we;
    logic [CELL_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [CELL_W-1:0] raddr;

    assign out_free        = !out_valid_reg || pop;
    assign empty           = !out_valid_reg;
    assign result          = out_reg;
    assign status.clearing = (state_reg == ST_BLANK) && !scroll_reg;

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        scroll_next = scroll_reg;
        hold_next   = hold_reg;
        out_next    = out_reg;
        load        = 1'b0;
        q_pop       = 1'b0;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = BLANK;
        raddr       = ptr_reg + CELL_W'(COLS);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    waddr = q_cmd.cell_idx;
                    wdata = q_cmd.data;
                    if (q_cmd.op == OP_SCROLL || q_cmd.op == OP_WRITE_SCROLL)
                    begin
                        we          = (q_cmd.op == OP_WRITE_SCROLL);
                        q_pop       = 1'b1;
                        hold_next   = q_cmd.res;
                        ptr_next    = '0;
                        scroll_next = 1'b1;
                        state_next  = ST_RD;
                    end
                    else if (out_free)
                    begin
                        we       = (q_cmd.op == OP_WRITE);
                        q_pop    = 1'b1;
                        load     = 1'b1;
                        out_next = q_cmd.res;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                we       = 1'b1;
                wdata    = rdata_reg;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == CELL_W'(CELLS - COLS - 1))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_BLANK:
            begin
                we = 1'b1;
                if (ptr_reg == CELL_W'(CELLS - 1))
                begin
                    state_next = scroll_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    out_next    = hold_reg;
                    scroll_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BLANK;
            ptr_reg       <= '0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    `TCC_ASSERT_NEXT(a_read_then_write, state_reg == ST_RD, state_reg == ST_WR)
    `TCC_ASSERT_SAME(a_no_result_overwrite, out_valid_reg && !pop, !load)
    `TCC_ASSERT_SAME(a_no_take_while_busy, state_reg != ST_IDLE, !q_pop)
    `TCC_ASSERT_SAME(a_ptr_in_range, 1'b1, ptr_reg < CELL_W'(CELLS))

endmodule

>>> rtl/text_console_cursor_scroll_core.sv
// Top level of the text console core: front end, command queue and store back end.
// Usage:
//   Requests enter through a queue-style port: drive request and raise push;
//   the beat is taken on a rising edge with push high and full low.
//   Results leave the same way: while empty is low, result holds the oldest
//   result; it is taken on a rising edge with pop high.
//   cfg_data loads the name table base on a cfg_valid/cfg_ready beat;
//   cfg_ready is always high. Write it only while the core is idle.
// Throughput and scrolling:
//   A request that does not scroll reaches the ports through the command queue
//   and the result register; such requests stream at one per cycle while
//   results are taken and no scroll is under way. A scroll reads then writes
//   each moved cell of the text memory, then blanks the last row; requests
//   keep queueing behind it until the two-entry queue fills.
// Reset:
//   rst_n clears the cursor to the top-left and sets the base to 2048, then a
//   clearing pass writes spaces to all 960 cells, one per cycle; full stays
//   high until the pass ends.
// Stall: with empty low and pop low the result holds; the back end then
//   stops at its next result and full rises once the queue is full.
`timescale 1ns / 1ps

module text_console_cursor_scroll_core
    import tcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  in_item_t          request,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output out_item_t         result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    cmd_t         q_din;
    cmd_t         q_dout;
    back_status_t back_status;

    tcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .request     (request),
        .full        (full),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .back_status (back_status),
        .cmd_push    (q_push),
        .cmd         (q_din)
    );

    tcc_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    tcc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_dout),
        .q_pop   (q_pop),
        .status  (back_status),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

>>> test/text_console_cursor_scroll_core_test.sv
// Self-checking bench for the text console core: shadow cursor and screen, directed and random requests.
`timescale 1ns / 1ps

module text_console_cursor_scroll_core_test;
    import tcc_pkg::*;

    localparam int         LIMIT        = 20_000_000;
    localparam int         IDLE_PCT     = 32;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         PHASE_ITEMS  = 475;
    localparam int         TAIL_CYCLES  = 2000;
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    class console_shadow;
        logic [ADDR_W-1:0] base;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic [7:0]        screen [CELLS];
        out_item_t         awaited_results[$];
        int                errors;

        function new();
            base    = BASE_RESET;
            cur_col = '0;
            cur_row = '0;
            errors  = 0;
            foreach (screen[i])
            begin
                screen[i] = BLANK;
            end
        endfunction

        function void park_cursor(logic [7:0] c, logic [7:0] r);
            if (c == 8'hFF)
            begin
                c = 8'(COLS - 1);
                r = r - 8'd1;
            end
            else if (c > 8'(COLS - 1))
            begin
                c = 8'd0;
                r = r + 8'd1;
            end
            if (r == 8'hFF)
            begin
                r = 8'(ROWS - 1);
            end
            else if (r > 8'(ROWS - 1))
            begin
                r = 8'd0;
            end
            cur_col = c[COL_W-1:0];
            cur_row = r[ROW_W-1:0];
        endfunction

        function void scroll_screen(inout out_item_t res);
            for (int i = 0; i < CELLS - COLS; i++)
            begin
                screen[i] = screen[i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++)
            begin
                screen[i] = BLANK;
            end
            cur_col      = '0;
            res.scrolled = 1'b1;
        endfunction

        function void write_cell(int idx, logic [7:0] ch, inout out_item_t res);
            screen[idx]    = ch;
            res.vram_write = 1'b1;
            res.vram_addr  = base + ADDR_W'(idx);
            res.vram_data  = ch;
        endfunction

        function void note_request(in_item_t rq);
            out_item_t  res;
            logic [7:0] c8;
            logic [7:0] r8;
            res = '0;
            c8  = 8'(cur_col);
            r8  = 8'(cur_row);
            case (rq.req_type)
                REQ_PUT:
                begin
                    write_cell(int'(cur_row) * COLS + int'(cur_col), rq.char_code, res);
                    if (cur_col == COLS - 1 && cur_row == ROWS - 1)
                    begin
                        scroll_screen(res);
                    end
                    else if (rq.advance)
                    begin
                        park_cursor(c8 + 8'd1, r8);
                    end
                end
                REQ_NL:
                begin
                    if (cur_row == ROWS - 1)
                    begin
                        scroll_screen(res);
                    end
                    else
                    begin
                        park_cursor(8'd0, r8 + 8'd1);
                    end
                end
                REQ_MOVE:
                begin
                    case (rq.direction)
                        DIR_UP:    park_cursor(c8, r8 - 8'd1);
                        DIR_DOWN:  park_cursor(c8, r8 + 8'd1);
                        DIR_LEFT:  park_cursor(c8 - 8'd1, r8);
                        DIR_RIGHT: park_cursor(c8 + 8'd1, r8);
                    endcase
                end
                REQ_SET:
                begin
                    park_cursor(rq.col, rq.row);
                end
                REQ_PUT_AT:
                begin
                    if (rq.col < COLS && rq.row < ROWS)
                    begin
                        write_cell(int'(rq.row) * COLS + int'(rq.col), rq.char_code, res);
                    end
                    else
                    begin
                        res.bad_location = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            res.cursor_col = cur_col;
            res.cursor_row = cur_row;
            awaited_results.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result beat with nothing awaited");
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            check_field("vram_write", 32'(want.vram_write), 32'(got.vram_write));
            check_field("vram_addr", 32'(want.vram_addr), 32'(got.vram_addr));
            check_field("vram_data", 32'(want.vram_data), 32'(got.vram_data));
            check_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
            check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
            check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
            check_field("bad_location", 32'(want.bad_location), 32'(got.bad_location));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              push      = 1'b0;
    in_item_t          request   = '0;
    logic              full;
    logic              empty;
    logic              pop       = 1'b0;
    out_item_t         result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data  = '0;

    logic          no_idle   = 1'b0;
    logic          hold_req  = 1'b0;
    int            hold_left = 0;
    int            cycles    = 0;
    console_shadow shadow    = new();

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_console_cursor_scroll_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic in_item_t req_item(logic [2:0] kind, logic adv, logic [7:0] ch,
                                          logic [1:0] dir, logic [7:0] c, logic [7:0] r);
        in_item_t rq;
        rq.req_type  = kind;
        rq.advance   = adv;
        rq.char_code = ch;
        rq.direction = dir;
        rq.col       = c;
        rq.row       = r;
        return rq;
    endfunction

    function automatic logic [7:0] pick_coord(int span);
        case ($urandom_range(0, 5))
            0, 1, 2: return 8'($urandom_range(0, span - 1));
            3:       return 8'hFF;
            4:       return 8'($urandom_range(span - 1, span));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_request();
        in_item_t rq;
        int       pick;
        rq   = $bits(in_item_t)'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            rq.req_type = REQ_PUT;
            rq.advance  = ($urandom_range(0, 9) < 8);
        end
        else if (pick < 45)
        begin
            rq.req_type = REQ_NL;
        end
        else if (pick < 63)
        begin
            rq.req_type = REQ_MOVE;
        end
        else if (pick < 78)
        begin
            rq.req_type = REQ_SET;
            rq.col      = pick_coord(COLS);
            rq.row      = pick_coord(ROWS);
        end
        else if (pick < 95)
        begin
            rq.req_type = REQ_PUT_AT;
            if ($urandom_range(0, 9) < 8)
            begin
                rq.col = 8'($urandom_range(0, COLS - 1));
                rq.row = 8'($urandom_range(0, ROWS - 1));
            end
        end
        else
        begin
            rq.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        end
        return rq;
    endfunction

    task automatic send_request(input in_item_t rq);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (full);
        shadow.note_request(rq);
    endtask

    task automatic drain();
        while (shadow.pending() != 0)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        shadow.base  = value;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_request(random_request());
        end
    endtask

    // result side: check each beat, stall at random or for a long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                shadow.check_result(result);
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("text_console_cursor_scroll_core: mismatch");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (full);

        write_base('1);
        send_request(req_item(REQ_PUT, 1'b1, 8'h41, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_PUT, 1'b0, 8'hFF, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_MOVE, 1'b0, 8'h00, DIR_LEFT, 8'd0, 8'd0));
        send_request(req_item(REQ_MOVE, 1'b0, 8'h00, DIR_LEFT, 8'd0, 8'd0));
        send_request(req_item(REQ_MOVE, 1'b0, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_MOVE, 1'b0, 8'h00, DIR_DOWN, 8'd0, 8'd0));
        send_request(req_item(REQ_MOVE, 1'b0, 8'h00, DIR_RIGHT, 8'd0, 8'd0));
        send_request(req_item(REQ_MOVE, 1'b0, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_SET, 1'b0, 8'h00, DIR_UP, 8'hFF, 8'd0));
        send_request(req_item(REQ_PUT, 1'b1, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_NL, 1'b0, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_SET, 1'b0, 8'h00, DIR_UP, 8'd39, 8'd5));
        send_request(req_item(REQ_PUT, 1'b1, 8'h7A, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_NL, 1'b0, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_SET, 1'b0, 8'h00, DIR_UP, 8'd40, 8'd23));
        send_request(req_item(REQ_SET, 1'b0, 8'h00, DIR_UP, 8'd0, 8'hFF));
        send_request(req_item(REQ_SET, 1'b0, 8'h00, DIR_UP, 8'd200, 8'd100));
        send_request(req_item(REQ_PUT_AT, 1'b0, 8'hFF, DIR_UP, 8'd39, 8'd23));
        send_request(req_item(REQ_PUT_AT, 1'b0, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_PUT_AT, 1'b0, 8'h55, DIR_UP, 8'd40, 8'd0));
        send_request(req_item(REQ_PUT_AT, 1'b0, 8'h55, DIR_UP, 8'd0, 8'd24));
        send_request(req_item(REQ_PUT_AT, 1'b1, 8'hAA, DIR_RIGHT, 8'hFF, 8'hFF));
        send_request(req_item(REQ_SPARE_LO, 1'b1, 8'hFF, DIR_RIGHT, 8'hFF, 8'hFF));
        send_request(req_item(3'(REQ_SPARE_LO + 3'd1), 1'b0, 8'h00, DIR_UP, 8'd0, 8'd0));
        send_request(req_item(REQ_SPARE_HI, 1'b1, 8'h5A, DIR_LEFT, 8'd12, 8'd7));

        drain();
        write_base('0);
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);

        drain();
        write_base(ADDR_W'($urandom));
        no_idle = 1'b1;
        run_random(PHASE_ITEMS / 2);
        drain();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
        no_idle = 1'b0;

        drain();
        write_base(BASE_RESET);
        run_random(PHASE_ITEMS);

        drain();
        write_base(ADDR_W'($urandom));
        run_random(PHASE_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
        begin
            $display("text_console_cursor_scroll_core: match");
        end
        else
        begin
            $display("text_console_cursor_scroll_core: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_cmd_fifo.sv
rtl/tcc_front.sv
rtl/tcc_back.sv
rtl/text_console_cursor_scroll_core.sv
test/text_console_cursor_scroll_core_test.sv
